// ----- rtl/core/rbm_pkg.sv -----
package rbm_pkg;

    localparam int AddrW  = 16;
    localparam int DataW  = 8;
    localparam int KeyW   = 4;
    localparam int PhysW  = 21;
    localparam int TgtW   = 3;
    localparam int RomBkW = 7;
    localparam int RamBkW = 2;
    localparam int GrpW   = 2;

    localparam logic [DataW-1:0] LowBankMask  = 8'h1F;
    localparam logic [DataW-1:0] RamEnKey     = 8'h0A;
    localparam logic [DataW-1:0] KeyHighBits  = 8'hC0;
    localparam logic [DataW-1:0] KeyNoneValue = 8'hCF;
    localparam logic [AddrW-1:0] KeypadAddr   = 16'hFF00;
    localparam logic [AddrW-1:0] UnusableLo   = 16'hFEA0;
    localparam logic [AddrW-1:0] UnusableHi   = 16'hFEFE;

    typedef enum logic [TgtW-1:0] {
        T_ROM      = 3'd0,
        T_XRAM     = 3'd1,
        T_INTERNAL = 3'd2,
        T_KEYPAD   = 3'd3,
        T_MAPPER   = 3'd4,
        T_IGNORED  = 3'd5
    } target_t;

    typedef struct packed {
        logic [RomBkW-1:0] rom_bank_select;
        logic [RamBkW-1:0] ram_bank_select;
        logic              ram_write_enable;
        logic              banking_mode;
        logic [GrpW-1:0]   keypad_group_select;
    } bank_state_t;

    typedef struct packed {
        logic              req_type;
        logic [AddrW-1:0]  address;
        logic [DataW-1:0]  write_data;
        logic [KeyW-1:0]   action_buttons;
        logic [KeyW-1:0]   direction_buttons;
    } access_t;

    typedef struct packed {
        target_t           target;
        logic [PhysW-1:0]  physical_address;
        logic              write_enable;
        logic [DataW-1:0]  keypad_value;
    } result_t;

endpackage

// ----- rtl/core/rom_ram_bank_mapper_with_keypad.sv -----
// an input transaction passes through the input register, then the result register, to result valid
// throughput: one transaction per cycle unless out_ready stalls, set by the single decode stage between the registers
// bank registers are written in the same cycle as the decoded result, so the next access
// sees them without a bubble
// reset: asynchronous active-low rst_n clears bank state, group select and both valid flags
module rom_ram_bank_mapper_with_keypad
    import rbm_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,

    input  logic              in_valid,
    output logic              in_ready,
    input  logic              req_type,
    input  logic [AddrW-1:0]  address,
    input  logic [DataW-1:0]  write_data,
    input  logic [KeyW-1:0]   action_buttons,
    input  logic [KeyW-1:0]   direction_buttons,

    output logic              out_valid,
    input  logic              out_ready,
    output logic [TgtW-1:0]   target,
    output logic [PhysW-1:0]  physical_address,
    output logic              write_enable,
    output logic [DataW-1:0]  keypad_value
);

    // input stage
    logic        in_valid_reg;
    access_t     acc_reg;

    // result stage
    logic        out_valid_reg;
    result_t     res_reg;

    // decode stage signals
    result_t     res_next;
    bank_state_t state;
    bank_state_t state_next;
    logic        advance;
    logic        fire;

    // result stage moves when empty or being drained
    assign advance  = !out_valid_reg || out_ready;
    // an access leaves the input register and commits its register writes
    assign fire     = in_valid_reg && advance;
    // the input register is free when empty or its contents move on this cycle
    assign in_ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                in_valid_reg <= in_valid;
            end
            if (advance)
            begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            acc_reg.req_type          <= req_type;
            acc_reg.address           <= address;
            acc_reg.write_data        <= write_data;
            acc_reg.action_buttons    <= action_buttons;
            acc_reg.direction_buttons <= direction_buttons;
        end
        if (fire)
        begin
            res_reg <= res_next;
        end
    end

    // address map decode and mapper register writes
    rbm_decode u_decode
    (
        .acc        (acc_reg),
        .state      (state),
        .res        (res_next),
        .state_next (state_next)
    );

    // bank, mode, ram enable and keypad group registers
    rbm_bank_regs u_bank_regs
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (fire),
        .state_next (state_next),
        .state      (state)
    );

    assign out_valid        = out_valid_reg;
    assign target           = res_reg.target;
    assign physical_address = res_reg.physical_address;
    assign write_enable     = res_reg.write_enable;
    assign keypad_value     = res_reg.keypad_value;

endmodule

// ----- rtl/core/rbm_bank_regs.sv -----
module rbm_bank_regs
    import rbm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        load,
    input  bank_state_t state_next,
    output bank_state_t state
);

    bank_state_t state_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
        end
        else if (load)
        begin
            state_reg <= state_next;
        end
    end

    assign state = state_reg;

endmodule

// ----- rtl/core/rbm_decode.sv -----
module rbm_decode
    import rbm_pkg::*;
(
    input  access_t     acc,
    input  bank_state_t state,
    output result_t     res,
    output bank_state_t state_next
);

    logic [RomBkW-1:0] rom_bank_eff;
    logic [DataW-1:0]  low_bits;
    logic [PhysW-1:0]  rom_phys;
    logic [PhysW-1:0]  ram_phys;
    logic [PhysW-1:0]  bus_phys;
    logic              is_xram;

    always_comb
    begin
        // low five bank bits of zero read as one
        rom_bank_eff = state.rom_bank_select;
        if (rom_bank_eff[4:0] == 5'd0)
        begin
            rom_bank_eff[0] = 1'b1;
        end
        low_bits = acc.write_data & LowBankMask;
        if (low_bits == '0)
        begin
            low_bits = 8'd1;
        end
        rom_phys = {rom_bank_eff, acc.address[13:0]};
        ram_phys = {6'd0, state.ram_bank_select, acc.address[12:0]};
        bus_phys = {5'd0, acc.address};
        is_xram  = (acc.address[15:13] == 3'b101);

        res.target           = T_INTERNAL;
        res.physical_address = bus_phys;
        res.write_enable     = 1'b0;
        res.keypad_value     = '0;
        state_next           = state;

        if (!acc.req_type)
        begin
            if (!acc.address[15])
            begin
                res.target = T_ROM;
                if (acc.address[14])
                begin
                    res.physical_address = rom_phys;
                end
            end
            else if (is_xram)
            begin
                res.target           = T_XRAM;
                res.physical_address = ram_phys;
            end
            else if (acc.address == KeypadAddr)
            begin
                res.target = T_KEYPAD;
                if (!state.keypad_group_select[1])
                begin
                    res.keypad_value = KeyHighBits | 8'h10 | {4'd0, acc.action_buttons};
                end
                else if (!state.keypad_group_select[0])
                begin
                    res.keypad_value = KeyHighBits | 8'h20 | {4'd0, acc.direction_buttons};
                end
                else
                begin
                    res.keypad_value = KeyNoneValue;
                end
            end
        end
        else
        begin
            if (!acc.address[15])
            begin
                res.target = T_MAPPER;
                case (acc.address[14:13])
                    2'd0:
                    begin
                        state_next.ram_write_enable = ((acc.write_data & RamEnKey) == RamEnKey);
                    end
                    2'd1:
                    begin
                        state_next.rom_bank_select[4:0] = low_bits[4:0];
                    end
                    2'd2:
                    begin
                        if (!state.banking_mode)
                        begin
                            state_next.rom_bank_select[6:5] = acc.write_data[1:0];
                        end
                        else
                        begin
                            state_next.ram_bank_select = acc.write_data[1:0];
                        end
                    end
                    2'd3:
                    begin
                        state_next.banking_mode = acc.write_data[0];
                    end
                    default:
                    begin
                        state_next = state;
                    end
                endcase
            end
            else if (is_xram)
            begin
                res.target           = T_XRAM;
                res.physical_address = ram_phys;
                res.write_enable     = state.ram_write_enable;
            end
            else if (acc.address inside {[UnusableLo:UnusableHi]})
            begin
                res.target = T_IGNORED;
            end
            else if (acc.address == KeypadAddr)
            begin
                res.target                     = T_KEYPAD;
                state_next.keypad_group_select = acc.write_data[5:4];
            end
            else
            begin
                res.write_enable = 1'b1;
            end
        end
    end

endmodule

// ----- rtl/core/rbm_checker.sv -----
module rbm_checker
    import rbm_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              out_valid,
    input logic              out_ready,
    input logic [TgtW-1:0]   target,
    input logic [PhysW-1:0]  physical_address,
    input logic              write_enable,
    input logic [DataW-1:0]  keypad_value
);

    // a stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(physical_address) && $stable(target))
    else $error("stalled result changed");

    // only ram and internal memory writes are performed
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && write_enable |-> target == T_XRAM || target == T_INTERNAL)
    else $error("write enable on wrong target");

    // keypad value only on keypad reads, with high bits set
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && keypad_value != '0 |-> target == T_KEYPAD && keypad_value[7:6] == 2'b11)
    else $error("bad keypad value");

    // banked rom window never maps to a bank with zero low bits
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && target == T_ROM |->
            physical_address[18:14] != 5'd0 || physical_address[20:14] == 7'd0)
    else $error("rom bank low bits zero");

endmodule

bind rom_ram_bank_mapper_with_keypad rbm_checker u_rbm_checker
(
    .clk              (clk),
    .rst_n            (rst_n),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .target           (target),
    .physical_address (physical_address),
    .write_enable     (write_enable),
    .keypad_value     (keypad_value)
);

// ----- tb/tb_rom_ram_bank_mapper_with_keypad.sv -----
module tb_rom_ram_bank_mapper_with_keypad;
    timeunit 1ns;
    timeprecision 1ps;

    import rbm_pkg::*;

    // access kinds on req_type
    localparam logic ReqRead  = 1'b0;
    localparam logic ReqWrite = 1'b1;

    // address windows of the bus map
    localparam logic [AddrW-1:0] RomFixedTop  = 16'h3FFF;
    localparam logic [AddrW-1:0] RomBankTop   = 16'h7FFF;
    localparam logic [AddrW-1:0] RamEnTop     = 16'h1FFF;
    localparam logic [AddrW-1:0] RomLowTop    = 16'h3FFF;
    localparam logic [AddrW-1:0] RomHighTop   = 16'h5FFF;
    localparam logic [AddrW-1:0] XramBase     = 16'hA000;
    localparam logic [AddrW-1:0] XramTop      = 16'hBFFF;

    localparam int NormalIdlePct = 14;
    localparam int StallLimit    = 1000;
    localparam int DrainCycles   = 8;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;

    logic              in_valid = 1'b0;
    logic              in_ready;
    logic              req_type = 1'b0;
    logic [AddrW-1:0]  address = '0;
    logic [DataW-1:0]  write_data = '0;
    logic [KeyW-1:0]   action_buttons = '1;
    logic [KeyW-1:0]   direction_buttons = '1;

    logic              out_valid;
    logic              out_ready = 1'b0;
    logic [TgtW-1:0]   target;
    logic [PhysW-1:0]  physical_address;
    logic              write_enable;
    logic [DataW-1:0]  keypad_value;

    // shadow copy of the mapper registers
    logic [RomBkW-1:0] rom_bank;
    logic [RamBkW-1:0] ram_bank;
    logic              ram_writes_on;
    logic              bank_mode;
    logic [GrpW-1:0]   key_group;

    result_t           pending_decodes[$];
    result_t           oldest_decode;
    int                idle_pct = NormalIdlePct;
    int                error_count = 0;
    int                stall_cycles = 0;

    rom_ram_bank_mapper_with_keypad u_top (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .req_type          (req_type),
        .address           (address),
        .write_data        (write_data),
        .action_buttons    (action_buttons),
        .direction_buttons (direction_buttons),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .target            (target),
        .physical_address  (physical_address),
        .write_enable      (write_enable),
        .keypad_value      (keypad_value)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    function automatic bit take_idle();
        return $urandom_range(99) < idle_pct;
    endfunction

    // decode one accepted access and update the shadow registers
    function automatic result_t decode_access(access_t acc);
        result_t           res;
        logic [RomBkW-1:0] bank;
        logic [4:0]        low;
        logic [PhysW-1:0]  xram_addr;
        logic              in_xram;
        begin
            res.target           = T_INTERNAL;
            res.physical_address = PhysW'(acc.address);
            res.write_enable     = 1'b0;
            res.keypad_value     = '0;
            in_xram   = (acc.address >= XramBase) && (acc.address <= XramTop);
            // bank times 0x2000 plus offset in the window
            xram_addr = PhysW'({ram_bank, acc.address[12:0]});
            if (acc.req_type == ReqRead)
            begin
                if (acc.address <= RomFixedTop)
                    res.target = T_ROM;
                else if (acc.address <= RomBankTop)
                begin
                    bank = rom_bank;
                    // a zero low field reads as bank one
                    if (bank[4:0] == 5'd0)
                        bank[0] = 1'b1;
                    res.target           = T_ROM;
                    res.physical_address = {bank, acc.address[13:0]};
                end
                else if (in_xram)
                begin
                    res.target           = T_XRAM;
                    res.physical_address = xram_addr;
                end
                else if (acc.address == KeypadAddr)
                begin
                    res.target = T_KEYPAD;
                    if (!key_group[1])
                        res.keypad_value = KeyHighBits | 8'h10 | DataW'(acc.action_buttons);
                    else if (!key_group[0])
                        res.keypad_value = KeyHighBits | 8'h20 | DataW'(acc.direction_buttons);
                    else
                        res.keypad_value = KeyNoneValue;
                end
            end
            else
            begin
                if (acc.address <= RamEnTop)
                begin
                    res.target    = T_MAPPER;
                    ram_writes_on = ((acc.write_data & RamEnKey) == RamEnKey);
                end
                else if (acc.address <= RomLowTop)
                begin
                    low = acc.write_data[4:0] & LowBankMask[4:0];
                    if (low == 5'd0)
                        low = 5'd1;
                    res.target    = T_MAPPER;
                    rom_bank[4:0] = low;
                end
                else if (acc.address <= RomHighTop)
                begin
                    res.target = T_MAPPER;
                    if (!bank_mode)
                        rom_bank[6:5] = acc.write_data[1:0];
                    else
                        ram_bank = acc.write_data[1:0];
                end
                else if (acc.address <= RomBankTop)
                begin
                    res.target = T_MAPPER;
                    bank_mode  = acc.write_data[0];
                end
                else if (in_xram)
                begin
                    res.target           = T_XRAM;
                    res.physical_address = xram_addr;
                    res.write_enable     = ram_writes_on;
                end
                else if ((acc.address >= UnusableLo) && (acc.address <= UnusableHi))
                    res.target = T_IGNORED;
                else if (acc.address == KeypadAddr)
                begin
                    res.target = T_KEYPAD;
                    key_group  = acc.write_data[5:4];
                end
                else
                    res.write_enable = 1'b1;
            end
            return res;
        end
    endfunction

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t ns: %s", $realtime, what);
        error_count++;
    endtask

    // drive one access, hold it until accepted, then record its decode
    task automatic send_access(input logic rt, input logic [AddrW-1:0] addr,
                               input logic [DataW-1:0] data, input logic [KeyW-1:0] act,
                               input logic [KeyW-1:0] dir);
        access_t acc;
        acc.req_type          = rt;
        acc.address           = addr;
        acc.write_data        = data;
        acc.action_buttons    = act;
        acc.direction_buttons = dir;
        while (take_idle())
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid          <= 1'b1;
        req_type          <= acc.req_type;
        address           <= acc.address;
        write_data        <= acc.write_data;
        action_buttons    <= acc.action_buttons;
        direction_buttons <= acc.direction_buttons;
        do
            @(posedge clk);
        while (!in_ready);
        pending_decodes.push_back(decode_access(acc));
    endtask

    // fixed window and banked window with the reset bank (zero read as one)
    task automatic test_rom_reads();
        send_access(ReqRead, 16'h0000, 8'h00, 4'hF, 4'hF);
        send_access(ReqRead, 16'h3FFF, 8'hFF, 4'h0, 4'h0);
        send_access(ReqRead, 16'h4000, 8'h00, 4'hF, 4'hF);
        send_access(ReqRead, 16'h7FFF, 8'hFF, 4'h0, 4'h0);
    endtask

    task automatic test_bank_writes();
        // low bank zero becomes one, then the widest low value
        send_access(ReqWrite, 16'h2000, 8'h00, 4'hF, 4'hF);
        send_access(ReqWrite, 16'h3FFF, 8'hFF, 4'hF, 4'hF);
        // upper bank bits in rom mode
        send_access(ReqWrite, 16'h4000, 8'h03, 4'hF, 4'hF);
        send_access(ReqRead,  16'h7FFF, 8'h00, 4'hF, 4'hF);
        // zero low field with upper bits set
        send_access(ReqWrite, 16'h2000, 8'h20, 4'hF, 4'hF);
        send_access(ReqRead,  16'h4000, 8'h00, 4'hF, 4'hF);
    endtask

    task automatic test_external_ram();
        send_access(ReqWrite, 16'h0000, 8'h0A, 4'hF, 4'hF);
        send_access(ReqWrite, 16'h6000, 8'hFF, 4'hF, 4'hF);
        send_access(ReqWrite, 16'h5FFF, 8'h03, 4'hF, 4'hF);
        send_access(ReqWrite, 16'hBFFF, 8'h5A, 4'hF, 4'hF);
        send_access(ReqRead,  16'hA000, 8'h00, 4'hF, 4'hF);
        // enable key missing: ram writes are dropped
        send_access(ReqWrite, 16'h1FFF, 8'hF5, 4'hF, 4'hF);
        send_access(ReqWrite, 16'hA000, 8'hA5, 4'hF, 4'hF);
    endtask

    task automatic test_keypad();
        send_access(ReqWrite, KeypadAddr, 8'h20, 4'hF, 4'hF);
        send_access(ReqRead,  KeypadAddr, 8'h00, 4'hF, 4'h0);
        send_access(ReqWrite, KeypadAddr, 8'h10, 4'h0, 4'h0);
        send_access(ReqRead,  KeypadAddr, 8'h00, 4'hF, 4'h0);
        // no group selected
        send_access(ReqWrite, KeypadAddr, 8'hFF, 4'hF, 4'hF);
        send_access(ReqRead,  KeypadAddr, 8'h00, 4'h0, 4'h0);
    endtask

    task automatic test_unusable_area();
        send_access(ReqWrite, UnusableLo, 8'h11, 4'hF, 4'hF);
        send_access(ReqWrite, UnusableHi, 8'h22, 4'hF, 4'hF);
        send_access(ReqWrite, 16'hFEFF, 8'h33, 4'hF, 4'hF);
        send_access(ReqRead,  16'hFFFF, 8'h00, 4'hF, 4'hF);
    endtask

    // weighted toward the mapped windows, with some fully random accesses
    task automatic test_random_traffic(input int count);
        int unsigned      pick;
        logic             rt;
        logic [AddrW-1:0] addr;
        repeat (count)
        begin
            pick = $urandom_range(99);
            rt   = 1'($urandom_range(1));
            if (pick < 20)
            begin
                rt   = ReqWrite;
                addr = 16'($urandom_range(RomBankTop));
            end
            else if (pick < 45)
            begin
                rt   = ReqRead;
                addr = 16'($urandom_range(RomBankTop));
            end
            else if (pick < 65)
                addr = 16'($urandom_range(XramTop, XramBase));
            else if (pick < 77)
                addr = KeypadAddr;
            else if (pick < 85)
                addr = 16'($urandom_range(16'hFF01, 16'hFE9F));
            else
                addr = 16'($urandom);
            send_access(rt, addr, 8'($urandom), 4'($urandom), 4'($urandom));
        end
    endtask

    task automatic test_back_to_back(input int count);
        idle_pct = 0;
        test_random_traffic(count);
        idle_pct = NormalIdlePct;
    endtask

    // result side stalls at random
    always @(posedge clk)
        out_ready <= !take_idle();

    // compare every result transaction with the oldest decode
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_decodes.size() == 0)
                report_mismatch("result transaction with nothing pending");
            else
            begin
                oldest_decode = pending_decodes.pop_front();
                if (target !== oldest_decode.target)
                    report_mismatch($sformatf("target %0d, wanted %s",
                                              target, oldest_decode.target.name()));
                if (physical_address !== oldest_decode.physical_address)
                    report_mismatch($sformatf("physical_address %h, wanted %h",
                                              physical_address,
                                              oldest_decode.physical_address));
                if (write_enable !== oldest_decode.write_enable)
                    report_mismatch($sformatf("write_enable %b, wanted %b",
                                              write_enable, oldest_decode.write_enable));
                if (keypad_value !== oldest_decode.keypad_value)
                    report_mismatch($sformatf("keypad_value %h, wanted %h",
                                              keypad_value, oldest_decode.keypad_value));
            end
        end
    end

    // no transaction on either side for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                stall_cycles <= 0;
            else if (stall_cycles >= StallLimit)
            begin
                $display("tb_rom_ram_bank_mapper_with_keypad failed");
                $finish;
            end
            else
                stall_cycles <= stall_cycles + 1;
        end
    end

    initial
    begin
        rom_bank      = '0;
        ram_bank      = '0;
        ram_writes_on = 1'b0;
        bank_mode     = 1'b0;
        key_group     = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_rom_reads();
        test_bank_writes();
        test_external_ram();
        test_keypad();
        test_unusable_area();
        test_random_traffic(300);
        test_back_to_back(150);
        in_valid <= 1'b0;

        while (pending_decodes.size() != 0)
            @(posedge clk);
        repeat (DrainCycles) @(posedge clk);

        if (error_count == 0)
            $display("tb_rom_ram_bank_mapper_with_keypad passed");
        else
            $display("tb_rom_ram_bank_mapper_with_keypad failed");
        $finish;
    end

endmodule
